>>> rtl/core/cc20_pkg.sv
package cc20_pkg;

	// rfc 8439 constant words
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	// 20 rounds x 4 quarter rounds x 4 add-xor-rotate steps
	localparam int RoundSteps = 320;
	localparam int CntW = $clog2(RoundSteps);

	typedef enum logic [2:0] {
		REG_KEY_A   = 3'd0,
		REG_KEY_B   = 3'd1,
		REG_KEY_C   = 3'd2,
		REG_KEY_D   = 3'd3,
		REG_NONCE_A = 3'd4,
		REG_NONCE_B = 3'd5,
		REG_INIT_CTR = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
	} out_item_t;

	// rotate of one quarter-round step: 16, 12, 8, 7
	function automatic logic [31:0] step_rot(logic [1:0] step, logic [31:0] v);
		logic [31:0] r;
		case (step)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[19:0], v[31:20]};
			2'd2: r = {v[23:0], v[31:24]};
			default: r = {v[24:0], v[31:25]};
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/cc20_stream_if.sv
interface cc20_stream_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/chacha20_keystream_xor.sv
// channel   dir  payload                 request accepted when
// din       in   data_byte[7:0], first   din.valid && din.ready
// dout      out  out_byte[7:0]           dout.valid && dout.ready
// apb cfg   in   64-bit regs at 8*index  psel && penable && pwrite (pready tied high)
//
// a byte whose keystream block is on hand is accepted, then emitted
// a byte that needs a new block goes through a load, 320 add-xor-rotate steps
// on one shared adder/rotator, 16 final word adds, then emit
// din.ready is high only in idle; one result sits in the output register while
// the next request is taken, emit waits for that register to drain
// arst_n clears control state and config to 0 (initial counter to 1)
module chacha20_keystream_xor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	cc20_stream_if.sink   din,
	cc20_stream_if.source dout
);

	logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q, nonce_a_q;
	logic [31:0] nonce_b_q, init_ctr_q;

	cc20_pkg::state_t state_q, state_nxt;

	logic [31:0]              ws_q [16];
	logic [31:0]              ws_nxt [16];
	logic [31:0]              init_w [16];
	logic [cc20_pkg::CntW-1:0] cnt_q;
	logic [31:0]              block_ctr_q;
	logic [5:0]               offset_q;
	logic                     block_ready_q;
	logic [7:0]               data_q;
	logic [7:0]               out_byte_q;
	logic [7:0]               out_byte_nxt;
	logic                     out_valid_q;

	logic cfg_wr, in_acc, need_block, round_last, final_last, slot_free;
	logic ld_en, rnd_en, fin_en, emit_en;

	cc20_pkg::reg_idx_t reg_idx;

	// ------------------------------------------------------------ config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = cc20_pkg::reg_idx_t'(paddr[5:3]);

	always_comb begin
		unique case (reg_idx)
			cc20_pkg::REG_KEY_A:    prdata = key_a_q;
			cc20_pkg::REG_KEY_B:    prdata = key_b_q;
			cc20_pkg::REG_KEY_C:    prdata = key_c_q;
			cc20_pkg::REG_KEY_D:    prdata = key_d_q;
			cc20_pkg::REG_NONCE_A:  prdata = nonce_a_q;
			cc20_pkg::REG_NONCE_B:  prdata = {32'd0, nonce_b_q};
			cc20_pkg::REG_INIT_CTR: prdata = {32'd0, init_ctr_q};
			default:                prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q    <= '0;
			key_b_q    <= '0;
			key_c_q    <= '0;
			key_d_q    <= '0;
			nonce_a_q  <= '0;
			nonce_b_q  <= '0;
			init_ctr_q <= 32'd1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				cc20_pkg::REG_KEY_A:    key_a_q    <= pwdata;
				cc20_pkg::REG_KEY_B:    key_b_q    <= pwdata;
				cc20_pkg::REG_KEY_C:    key_c_q    <= pwdata;
				cc20_pkg::REG_KEY_D:    key_d_q    <= pwdata;
				cc20_pkg::REG_NONCE_A:  nonce_a_q  <= pwdata;
				cc20_pkg::REG_NONCE_B:  nonce_b_q  <= pwdata[31:0];
				cc20_pkg::REG_INIT_CTR: init_ctr_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ sequencer
	assign in_acc     = din.valid && din.ready;
	assign need_block = din.payload.first || !block_ready_q;
	assign round_last = cnt_q == cc20_pkg::CntW'(cc20_pkg::RoundSteps - 1);
	assign final_last = cnt_q[3:0] == 4'hf;
	assign slot_free  = !out_valid_q || dout.ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cc20_pkg::ST_IDLE:  if (din.valid) state_nxt = need_block ? cc20_pkg::ST_LOAD
				: cc20_pkg::ST_EMIT;
			cc20_pkg::ST_LOAD:  state_nxt = cc20_pkg::ST_ROUND;
			cc20_pkg::ST_ROUND: if (round_last) state_nxt = cc20_pkg::ST_FINAL;
			cc20_pkg::ST_FINAL: if (final_last) state_nxt = cc20_pkg::ST_EMIT;
			cc20_pkg::ST_EMIT:  if (slot_free) state_nxt = cc20_pkg::ST_IDLE;
			default:            state_nxt = cc20_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		din.ready = 1'b0;
		ld_en     = 1'b0;
		rnd_en    = 1'b0;
		fin_en    = 1'b0;
		emit_en   = 1'b0;
		unique case (state_q)
			cc20_pkg::ST_IDLE:  din.ready = 1'b1;
			cc20_pkg::ST_LOAD:  ld_en = 1'b1;
			cc20_pkg::ST_ROUND: rnd_en = 1'b1;
			cc20_pkg::ST_FINAL: fin_en = 1'b1;
			cc20_pkg::ST_EMIT:  emit_en = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cc20_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------ block state
	always_comb begin
		init_w[0]  = cc20_pkg::SIGMA0;
		init_w[1]  = cc20_pkg::SIGMA1;
		init_w[2]  = cc20_pkg::SIGMA2;
		init_w[3]  = cc20_pkg::SIGMA3;
		init_w[4]  = key_a_q[31:0];
		init_w[5]  = key_a_q[63:32];
		init_w[6]  = key_b_q[31:0];
		init_w[7]  = key_b_q[63:32];
		init_w[8]  = key_c_q[31:0];
		init_w[9]  = key_c_q[63:32];
		init_w[10] = key_d_q[31:0];
		init_w[11] = key_d_q[63:32];
		init_w[12] = block_ctr_q;
		init_w[13] = nonce_a_q[31:0];
		init_w[14] = nonce_a_q[63:32];
		init_w[15] = nonce_b_q;
	end

	// the quarter round always works on fixed slots: column 0,4,8,12 or
	// diagonal 0,5,10,15; after its last step every row rotates left by one
	// word so the next quarter round lands on the same slots
	always_comb begin
		logic        diag, even;
		logic [3:0]  pb, pc, pd;
		logic [31:0] op1, op2, xr, sum, rot;
		logic [31:0] upd [16];

		diag = cnt_q[4];
		even = !cnt_q[0];
		pb   = diag ? 4'd5 : 4'd4;
		pc   = diag ? 4'd10 : 4'd8;
		pd   = diag ? 4'd15 : 4'd12;
		// the final word adds share the round adder
		op1  = (fin_en || even) ? ws_q[0] : ws_q[pc];
		op2  = fin_en ? init_w[cnt_q[3:0]] : (even ? ws_q[pb] : ws_q[pd]);
		xr   = even ? ws_q[pd] : ws_q[pb];
		sum  = op1 + op2;
		rot  = cc20_pkg::step_rot(cnt_q[1:0], xr ^ sum);

		upd = ws_q;
		if (even) begin
			upd[0]  = sum;
			upd[pd] = rot;
		end else begin
			upd[pc] = sum;
			upd[pb] = rot;
		end

		ws_nxt = ws_q;
		if (ld_en) begin
			ws_nxt = init_w;
		end else if (rnd_en) begin
			if (cnt_q[1:0] == 2'd3) begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						ws_nxt[4*r+j] = upd[4*r+((j+1)%4)];
					end
				end
			end else begin
				ws_nxt = upd;
			end
		end else if (fin_en) begin
			// shift the words down one slot and put slot 0 plus its input word in slot 15
			for (int i = 0; i < 15; i++) begin
				ws_nxt[i] = ws_q[i+1];
			end
			ws_nxt[15] = sum;
		end
	end

	always_ff @(posedge clk) begin
		ws_q <= ws_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld_en || (rnd_en && round_last)) begin
			cnt_q <= '0;
		end else if (rnd_en || fin_en) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// ------------------------------------------------------------ stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_ctr_q   <= '0;
			offset_q      <= '0;
			block_ready_q <= 1'b0;
		end else begin
			if (in_acc && din.payload.first) begin
				block_ctr_q   <= init_ctr_q;
				offset_q      <= '0;
				block_ready_q <= 1'b0;
			end else if (fin_en && final_last) begin
				block_ctr_q   <= block_ctr_q + 32'd1;
				block_ready_q <= 1'b1;
			end else if (emit_en) begin
				offset_q <= offset_q + 6'd1;
				if (offset_q == 6'd63) block_ready_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) data_q <= din.payload.data_byte;
	end

	// ------------------------------------------------------------ output register
	always_comb begin
		logic [31:0] word;
		word = ws_q[offset_q[5:2]];
		dout.valid            = out_valid_q;
		dout.payload.out_byte = out_byte_q;
		if (emit_en) begin
			out_byte_nxt = data_q ^ word[{offset_q[1:0], 3'b000} +: 8];
		end else begin
			out_byte_nxt = out_byte_q;
		end
	end

	always_ff @(posedge clk) begin
		out_byte_q <= out_byte_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> tb/chacha20_keystream_xor_test.sv
`timescale 1ns / 1ps

module chacha20_keystream_xor_test;

	localparam logic [31:0] CONST_W0 = 32'h61707865;
	localparam logic [31:0] CONST_W1 = 32'h3320646e;
	localparam logic [31:0] CONST_W2 = 32'h79622d32;
	localparam logic [31:0] CONST_W3 = 32'h6b206574;
	// address just past the register list, writes there are dropped
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_BYTES = 48;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PRINT_CAP = 200;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	cc20_stream_if #(.payload_t(cc20_pkg::in_item_t))  din_if ();
	cc20_stream_if #(.payload_t(cc20_pkg::out_item_t)) dout_if ();

	chacha20_keystream_xor dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.din(din_if),
		.dout(dout_if)
	);

	always #2 clk = ~clk;

	cc20_pkg::in_item_t  pending_bytes[$];
	cc20_pkg::out_item_t expected_out[$];
	int        errors = 0;
	int        cycles = 0;
	bit        calm = 1'b0;
	int        send_pause = 0;
	int        recv_stall = 0;

	// shadow of the configuration registers
	logic [31:0] key_w [8];
	logic [31:0] nonce_w [3];
	logic [31:0] start_ctr = 32'd1;

	// keystream state
	logic [31:0] ks_words [16];
	logic [5:0]  byte_pos = '0;
	logic [31:0] next_ctr = '0;
	bit          block_valid = 1'b0;

	initial begin
		for (int i = 0; i < 8; i++) key_w[i] = '0;
		for (int i = 0; i < 3; i++) nonce_w[i] = '0;
		for (int i = 0; i < 16; i++) ks_words[i] = '0;
	end

	function automatic logic [31:0] rotl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void make_keystream(logic [31:0] ctr);
		logic [31:0] seed [16];
		logic [31:0] x [16];
		logic [31:0] va, vb, vc, vd;
		int ia, ib, ic, ix, qq, r, q, i;
		seed[0] = CONST_W0;
		seed[1] = CONST_W1;
		seed[2] = CONST_W2;
		seed[3] = CONST_W3;
		for (i = 0; i < 8; i++) seed[4 + i] = key_w[i];
		seed[12] = ctr;
		for (i = 0; i < 3; i++) seed[13 + i] = nonce_w[i];
		for (i = 0; i < 16; i++) x[i] = seed[i];
		for (r = 0; r < 10; r++) begin
			for (q = 0; q < 8; q++) begin
				qq = q % 4;
				ia = qq;
				// columns first, then diagonals
				if (q < 4) begin
					ib = 4 + qq;
					ic = 8 + qq;
					ix = 12 + qq;
				end else begin
					ib = 4 + (qq + 1) % 4;
					ic = 8 + (qq + 2) % 4;
					ix = 12 + (qq + 3) % 4;
				end
				va = x[ia]; vb = x[ib]; vc = x[ic]; vd = x[ix];
				va = va + vb; vd = rotl(vd ^ va, 16);
				vc = vc + vd; vb = rotl(vb ^ vc, 12);
				va = va + vb; vd = rotl(vd ^ va, 8);
				vc = vc + vd; vb = rotl(vb ^ vc, 7);
				x[ia] = va; x[ib] = vb; x[ic] = vc; x[ix] = vd;
			end
		end
		for (i = 0; i < 16; i++) ks_words[i] = x[i] + seed[i];
	endfunction

	function automatic cc20_pkg::out_item_t cipher_byte(cc20_pkg::in_item_t req);
		logic [31:0] word;
		cc20_pkg::out_item_t res;
		if (req.first) begin
			next_ctr = start_ctr;
			byte_pos = '0;
			block_valid = 1'b0;
		end
		if (!block_valid) begin
			make_keystream(next_ctr);
			next_ctr = next_ctr + 32'd1;
			block_valid = 1'b1;
		end
		word = ks_words[byte_pos[5:2]];
		res.out_byte = req.data_byte ^ word[byte_pos[1:0] * 8 +: 8];
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == '0) block_valid = 1'b0;
		return res;
	endfunction

	function automatic void apply_cfg(logic [2:0] idx, logic [63:0] value);
		case (idx)
			cc20_pkg::REG_KEY_A: begin
				key_w[0] = value[31:0];
				key_w[1] = value[63:32];
			end
			cc20_pkg::REG_KEY_B: begin
				key_w[2] = value[31:0];
				key_w[3] = value[63:32];
			end
			cc20_pkg::REG_KEY_C: begin
				key_w[4] = value[31:0];
				key_w[5] = value[63:32];
			end
			cc20_pkg::REG_KEY_D: begin
				key_w[6] = value[31:0];
				key_w[7] = value[63:32];
			end
			cc20_pkg::REG_NONCE_A: begin
				nonce_w[0] = value[31:0];
				nonce_w[1] = value[63:32];
			end
			cc20_pkg::REG_NONCE_B: nonce_w[2] = value[31:0];
			cc20_pkg::REG_INIT_CTR: start_ctr = value[31:0];
			default: ;
		endcase
	endfunction

	function automatic int draw_pause();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string msg);
		if (errors < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_if.valid <= 1'b0;
			din_if.payload <= '0;
			send_pause <= 0;
		end else if (!din_if.valid || din_if.ready) begin
			if (din_if.valid) expected_out.push_back(cipher_byte(din_if.payload));
			if (send_pause > 0) begin
				din_if.valid <= 1'b0;
				send_pause <= send_pause - 1;
			end else if (pending_bytes.size() != 0) begin
				din_if.valid <= 1'b1;
				din_if.payload <= pending_bytes.pop_front();
				send_pause <= draw_pause();
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		cc20_pkg::out_item_t want;
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (dout_if.valid && dout_if.ready) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", dout_if.payload.out_byte));
				end else begin
					want = expected_out.pop_front();
					if (dout_if.payload.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %02h, want %02h",
							dout_if.payload.out_byte, want.out_byte));
				end
			end
			if (recv_stall > 0) begin
				dout_if.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				dout_if.ready <= 1'b1;
				if (dout_if.valid && dout_if.ready) recv_stall <= draw_pause();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apply_cfg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || din_if.valid || expected_out.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_byte(input logic [7:0] data, input bit first);
		cc20_pkg::in_item_t req;
		req.data_byte = data;
		req.first = first;
		pending_bytes.push_back(req);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return $urandom_range(1, 4);
		if (r < 8) return $urandom_range(5, 64);
		return $urandom_range(65, 140);
	endfunction

	initial begin
		int count, len;
		din_if.valid = 1'b0;
		din_if.payload = '0;
		dout_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// stream without a first flag right after reset runs from counter 0
		@(negedge clk);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h5a, 1'b0);
		wait_idle();

		cfg_write(cc20_pkg::REG_KEY_A, '1);
		cfg_write(cc20_pkg::REG_KEY_B, '1);
		cfg_write(cc20_pkg::REG_KEY_C, '1);
		cfg_write(cc20_pkg::REG_KEY_D, '1);
		cfg_write(cc20_pkg::REG_NONCE_A, '1);
		cfg_write(cc20_pkg::REG_NONCE_B, '1);
		cfg_write(cc20_pkg::REG_INIT_CTR, '0);
		cfg_write(REG_UNUSED, 64'h0123456789abcdef);
		@(negedge clk);
		queue_byte(8'hff, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7f, 1'b0);
		// restart in the middle of a message
		queue_byte(8'h00, 1'b1);
		queue_byte(8'haa, 1'b0);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'hfe, 1'b0);
		wait_idle();

		// key change mid-message, the current block stays in use
		cfg_write(cc20_pkg::REG_KEY_A, '0);
		cfg_write(cc20_pkg::REG_KEY_B, '0);
		cfg_write(cc20_pkg::REG_KEY_C, '0);
		cfg_write(cc20_pkg::REG_KEY_D, '0);
		cfg_write(cc20_pkg::REG_NONCE_A, '0);
		cfg_write(cc20_pkg::REG_NONCE_B, '0);
		cfg_write(cc20_pkg::REG_INIT_CTR, 64'h00000000_ffffffff);
		@(negedge clk);
		queue_byte(8'h3c, 1'b0);
		queue_byte(8'hc3, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h10, 1'b0);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			calm = (p % 4 == 3);
			if (p == 0) begin
				cfg_write(cc20_pkg::REG_KEY_A, {$urandom, $urandom});
				cfg_write(cc20_pkg::REG_KEY_B, {$urandom, $urandom});
				cfg_write(cc20_pkg::REG_KEY_C, {$urandom, $urandom});
				cfg_write(cc20_pkg::REG_KEY_D, {$urandom, $urandom});
				cfg_write(cc20_pkg::REG_NONCE_A, {$urandom, $urandom});
				cfg_write(cc20_pkg::REG_NONCE_B, {$urandom, $urandom});
				// counter wraps inside the first long message
				cfg_write(cc20_pkg::REG_INIT_CTR, {$urandom, 32'hffffffff});
			end else begin
				if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_A, pick_value());
				if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_B, pick_value());
				if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_C, pick_value());
				if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_D, pick_value());
				if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_NONCE_A, pick_value());
				if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_NONCE_B, pick_value());
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 4))
						0: cfg_write(cc20_pkg::REG_INIT_CTR, 64'h0);
						1: cfg_write(cc20_pkg::REG_INIT_CTR, 64'hffffffff);
						2: cfg_write(cc20_pkg::REG_INIT_CTR, 64'hfffffffe);
						3: cfg_write(cc20_pkg::REG_INIT_CTR, 64'h1);
						default: cfg_write(cc20_pkg::REG_INIT_CTR, {$urandom, $urandom});
					endcase
				end
				if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, pick_value());
			end
			@(negedge clk);
			count = 0;
			while (count < PHASE_BYTES) begin
				len = (p == 0 && count == 0) ? 130 : pick_len();
				// sometimes carry on the stream left from the last phase
				for (int i = 0; i < len; i++)
					queue_byte(8'($urandom_range(0, 255)),
						i == 0 && (p == 0 || count != 0 || $urandom_range(0, 9) > 2));
				count += len;
			end
			wait_idle();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
